@@ sv/hed_pkg.sv @@
package hed_pkg;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_FEED,
        ST_UTF,
        ST_FLUSH
    } t_state;

    typedef enum logic [2:0] {
        NM_AMP,
        NM_LT,
        NM_GT,
        NM_QUOT,
        NM_APOS
    } t_name;

    localparam int NAME_NUM = 5;

    localparam logic [7:0] CH_AMP  = 8'h26;
    localparam logic [7:0] CH_SEMI = 8'h3B;
    localparam logic [7:0] CH_HASH = 8'h23;
    localparam logic [7:0] CH_LT   = 8'h3C;
    localparam logic [7:0] CH_GT   = 8'h3E;
    localparam logic [7:0] CH_QUOT = 8'h22;
    localparam logic [7:0] CH_APOS = 8'h27;

    // Result of a reference closed by a semicolon at the current window position
    typedef struct packed {
        logic       named_ok;
        logic [7:0] named_byte;
        logic       num_ok;
        logic [2:0] utf_len;
    } t_verdict;

    function automatic logic [2:0] name_len(input t_name nm);
        logic [2:0] len;
        unique case (nm) inside
            NM_AMP:             len = 3'd3;
            NM_LT, NM_GT:       len = 3'd2;
            NM_QUOT, NM_APOS:   len = 3'd4;
            default:            len = 3'd0;
        endcase
        return len;
    endfunction

    function automatic logic [7:0] name_out(input t_name nm);
        logic [7:0] ch;
        unique case (nm)
            NM_AMP:  ch = CH_AMP;
            NM_LT:   ch = CH_LT;
            NM_GT:   ch = CH_GT;
            NM_QUOT: ch = CH_QUOT;
            NM_APOS: ch = CH_APOS;
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

    // Lower-case spelling of each entity name, one letter per index
    function automatic logic [7:0] name_char(input t_name nm, input logic [1:0] idx);
        logic [7:0] ch;
        ch = 8'h00;
        unique case (nm)
            NM_AMP: begin
                case (idx)
                    2'd0:    ch = 8'h61;
                    2'd1:    ch = 8'h6D;
                    default: ch = 8'h70;
                endcase
            end
            NM_LT:   ch = (idx == 2'd0) ? 8'h6C : 8'h74;
            NM_GT:   ch = (idx == 2'd0) ? 8'h67 : 8'h74;
            NM_QUOT: begin
                case (idx)
                    2'd0:    ch = 8'h71;
                    2'd1:    ch = 8'h75;
                    2'd2:    ch = 8'h6F;
                    default: ch = 8'h74;
                endcase
            end
            NM_APOS: begin
                case (idx)
                    2'd0:    ch = 8'h61;
                    2'd1:    ch = 8'h70;
                    2'd2:    ch = 8'h6F;
                    default: ch = 8'h73;
                endcase
            end
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

    // Byte idx of the UTF-8 form of cp, len bytes long (4 for everything from 0x10000 up)
    function automatic logic [7:0] utf8_byte(input logic [31:0] cp, input logic [2:0] len,
                                             input logic [1:0] idx);
        logic [7:0] b;
        logic [1:0] tail;
        tail = len[1:0] - 2'd1 - idx;
        if (idx == 2'd0) begin
            case (len)
                3'd1:    b = cp[7:0];
                3'd2:    b = 8'hC0 | {3'b000, cp[10:6]};
                3'd3:    b = 8'hE0 | {4'b0000, cp[15:12]};
                default: b = 8'hF0 | cp[25:18];
            endcase
        end else begin
            case (tail)
                2'd0:    b = {2'b10, cp[5:0]};
                2'd1:    b = {2'b10, cp[11:6]};
                default: b = {2'b10, cp[17:12]};
            endcase
        end
        return b;
    endfunction

endpackage

@@ sv/hed_ref_parse.sv @@
module hed_ref_parse #(
    parameter int POS_W = 4
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_open,
    input  logic                i_append,
    input  logic [7:0]          i_byte,
    input  logic [POS_W-1:0]    i_pos,
    output hed_pkg::t_verdict   o_verdict,
    output logic [31:0]         o_cp
);

    logic [hed_pkg::NAME_NUM-1:0] r_match;
    logic                         r_num;
    logic                         r_hex;
    logic                         r_any;
    logic                         r_bad;
    logic [31:0]                  r_cp;

    logic [7:0]  folded;
    logic [4:0]  digit;
    logic [1:0]  name_idx;

    function automatic logic [4:0] dig_val(input logic [7:0] c, input logic hex);
        logic [4:0] d;
        if (c >= 8'h30 && c <= 8'h39) begin
            d = {1'b1, 4'(c - 8'h30)};
        end else if (hex && c >= 8'h61 && c <= 8'h66) begin
            d = {1'b1, 4'(c - 8'h57)};
        end else if (hex && c >= 8'h41 && c <= 8'h46) begin
            d = {1'b1, 4'(c - 8'h37)};
        end else begin
            d = 5'd0;
        end
        return d;
    endfunction

    assign folded   = (i_byte >= 8'h41 && i_byte <= 8'h5A) ? (i_byte + 8'd32) : i_byte;
    assign digit    = dig_val(i_byte, r_hex);
    assign name_idx = 2'(i_pos - POS_W'(1));
    assign o_cp     = r_cp;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_match <= '0;
            r_num   <= 1'b0;
            r_hex   <= 1'b0;
            r_any   <= 1'b0;
            r_bad   <= 1'b0;
            r_cp    <= '0;
        end else if (i_open) begin
            r_match <= '1;
            r_num   <= 1'b0;
            r_hex   <= 1'b0;
            r_any   <= 1'b0;
            r_bad   <= 1'b0;
            r_cp    <= '0;
        end else if (i_append && i_byte != hed_pkg::CH_SEMI) begin
            for (int n = 0; n < hed_pkg::NAME_NUM; n++) begin
                if (i_pos <= POS_W'(hed_pkg::name_len(hed_pkg::t_name'(n)))) begin
                    r_match[n] <= r_match[n] &&
                        (folded == hed_pkg::name_char(hed_pkg::t_name'(n), name_idx));
                end else begin
                    r_match[n] <= 1'b0;
                end
            end
            if (i_pos == POS_W'(1)) begin
                r_num <= (i_byte == hed_pkg::CH_HASH);
            end else if (r_num) begin
                if (i_pos == POS_W'(2) && (i_byte == 8'h78 || i_byte == 8'h58)) begin
                    r_hex <= 1'b1;
                end else if (digit[4]) begin
                    // accumulate modulo 2^32: x16 is a shift, x10 is x8 + x2
                    r_cp  <= r_hex ? {r_cp[27:0], digit[3:0]}
                                   : ({r_cp[28:0], 3'b000} + {r_cp[30:0], 1'b0}
                                      + {28'd0, digit[3:0]});
                    r_any <= 1'b1;
                end else begin
                    r_bad <= 1'b1;
                end
            end
        end
    end

    always_comb begin
        o_verdict = '0;
        for (int n = 0; n < hed_pkg::NAME_NUM; n++) begin
            if (r_match[n] && i_pos == POS_W'(hed_pkg::name_len(hed_pkg::t_name'(n))) + POS_W'(1))
            begin
                o_verdict.named_ok   = 1'b1;
                o_verdict.named_byte = hed_pkg::name_out(hed_pkg::t_name'(n));
            end
        end
        o_verdict.num_ok = r_num && r_any && !r_bad && (r_cp != '0);
        if (r_cp < 32'h80) begin
            o_verdict.utf_len = 3'd1;
        end else if (r_cp < 32'h800) begin
            o_verdict.utf_len = 3'd2;
        end else if (r_cp < 32'h10000) begin
            o_verdict.utf_len = 3'd3;
        end else begin
            o_verdict.utf_len = 3'd4;
        end
    end

endmodule

@@ sv/html_entity_decoder.sv @@
// Streaming HTML character-reference decoder. Bytes of one field come in on the slave side,
// tlast on the final byte; decoded bytes leave on the master side, tlast on the final decoded
// byte of the field. Named entities amp, lt, gt, quot and apos (any case) and decimal or hex
// numeric references become one byte or UTF-8 of up to four bytes; a reference whose semicolon
// is missing within REF_WINDOW bytes of the ampersand, or which does not parse, passes its
// ampersand through and its held bytes are scanned again; bytes still held at the end of a
// field leave as they stand. A plain-text input word is accepted in ST_IDLE and then passes
// one feed step through the held-byte buffer; the bytes of a numeric reference leave from
// ST_UTF, held bytes after a failed reference are fed again and bytes held at the end of a
// field leave from ST_FLUSH. A new word is taken only in ST_IDLE, and no step moves while
// the one-word output register is full and untaken; the held-byte buffer has one read port.
module html_entity_decoder #(
    parameter int REF_WINDOW = 12
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_s_tvalid,
    output logic       o_s_tready,
    input  logic [7:0] i_s_tdata,   // [7:0] in_byte
    input  logic       i_s_tlast,   // in_last
    output logic       o_m_tvalid,
    input  logic       i_m_tready,
    output logic [7:0] o_m_tdata,   // [7:0] out_byte
    output logic       o_m_tlast    // out_last
);

    localparam int WIN_DEPTH = REF_WINDOW + 1;
    localparam int AW        = $clog2(WIN_DEPTH);
    localparam int CW        = $clog2(WIN_DEPTH + 1);
    localparam int DEPTH     = 1 << AW;

    hed_pkg::t_state r_state, n_state;

    logic [7:0]    r_buf [DEPTH];
    logic [AW-1:0] r_head, n_head;
    logic [CW-1:0] r_cnt, n_cnt;
    logic [CW-1:0] r_q, n_q;
    logic          r_last, n_last;
    logic [2:0]    r_len, n_len;
    logic [1:0]    r_idx, n_idx;
    logic          r_out_valid, n_out_valid;
    logic [7:0]    r_out_byte, n_out_byte;
    logic          r_out_last, n_out_last;

    logic              accept;
    logic              slot_free;
    logic [AW-1:0]     rd_addr;
    logic [7:0]        fb;
    logic [CW-1:0]     cnt_inc;
    logic [AW-1:0]     head_skip;
    logic              utf_done;
    logic              p_open;
    logic              p_append;
    logic              num_hit;
    logic              emit;
    logic [7:0]        emit_byte;
    logic              emit_last;
    hed_pkg::t_verdict verdict;
    logic [31:0]       cp;

    assign o_s_tready = (r_state == hed_pkg::ST_IDLE);
    assign accept     = i_s_tvalid && o_s_tready;
    assign slot_free  = !r_out_valid || i_m_tready;
    assign rd_addr    = (r_state == hed_pkg::ST_FLUSH) ? r_head : (r_head + r_cnt[AW-1:0]);
    assign fb         = r_buf[rd_addr];
    assign cnt_inc    = r_cnt + CW'(1);
    assign head_skip  = r_head + cnt_inc[AW-1:0];
    assign utf_done   = (({1'b0, r_idx} + 3'd1) == r_len);

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_byte;
    assign o_m_tlast  = r_out_last;

    hed_ref_parse #(
        .POS_W (CW)
    ) u_parse (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_open    (p_open),
        .i_append  (p_append),
        .i_byte    (fb),
        .i_pos     (r_cnt),
        .o_verdict (verdict),
        .o_cp      (cp)
    );

    // Sequencer actions and register updates
    always_comb begin
        n_head    = r_head;
        n_cnt     = r_cnt;
        n_q       = r_q;
        n_last    = r_last;
        n_len     = r_len;
        n_idx     = r_idx;
        p_open    = 1'b0;
        p_append  = 1'b0;
        num_hit   = 1'b0;
        emit      = 1'b0;
        emit_byte = fb;
        emit_last = 1'b0;
        unique case (r_state)
            hed_pkg::ST_IDLE: begin
                if (accept) begin
                    n_q    = CW'(1);
                    n_last = i_s_tlast;
                end
            end
            hed_pkg::ST_FEED: begin
                if (slot_free) begin
                    n_q = r_q - CW'(1);
                    if (r_cnt == '0) begin
                        if (fb == hed_pkg::CH_AMP) begin
                            p_open = 1'b1;
                            n_cnt  = CW'(1);
                        end else begin
                            emit      = 1'b1;
                            emit_last = r_last && (r_q == CW'(1));
                            n_head    = r_head + AW'(1);
                        end
                    end else begin
                        p_append = 1'b1;
                        if (fb == hed_pkg::CH_SEMI && verdict.named_ok) begin
                            emit      = 1'b1;
                            emit_byte = verdict.named_byte;
                            emit_last = r_last && (r_q == CW'(1));
                            n_head    = head_skip;
                            n_cnt     = '0;
                        end else if (fb == hed_pkg::CH_SEMI && verdict.num_ok) begin
                            num_hit = 1'b1;
                            n_head  = head_skip;
                            n_cnt   = '0;
                            n_len   = verdict.utf_len;
                            n_idx   = '0;
                        end else if (fb == hed_pkg::CH_SEMI || cnt_inc == CW'(WIN_DEPTH)) begin
                            // pass the ampersand, requeue the held bytes after it
                            emit      = 1'b1;
                            emit_byte = hed_pkg::CH_AMP;
                            n_head    = r_head + AW'(1);
                            n_q       = r_q - CW'(1) + r_cnt;
                            n_cnt     = '0;
                        end else begin
                            n_cnt = cnt_inc;
                        end
                    end
                end
            end
            hed_pkg::ST_UTF: begin
                if (slot_free) begin
                    emit      = 1'b1;
                    emit_byte = hed_pkg::utf8_byte(cp, r_len, r_idx);
                    emit_last = r_last && (r_q == '0) && utf_done;
                    n_idx     = r_idx + 2'd1;
                end
            end
            hed_pkg::ST_FLUSH: begin
                if (slot_free) begin
                    emit      = 1'b1;
                    emit_last = (r_cnt == CW'(1));
                    n_head    = r_head + AW'(1);
                    n_cnt     = r_cnt - CW'(1);
                end
            end
            default: begin
                n_q = r_q;
            end
        endcase

        if (emit) begin
            n_out_valid = 1'b1;
            n_out_byte  = emit_byte;
            n_out_last  = emit_last;
        end else begin
            n_out_valid = r_out_valid && !i_m_tready;
            n_out_byte  = r_out_byte;
            n_out_last  = r_out_last;
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            hed_pkg::ST_IDLE: begin
                if (accept) begin
                    n_state = hed_pkg::ST_FEED;
                end
            end
            hed_pkg::ST_FEED: begin
                if (slot_free) begin
                    if (num_hit) begin
                        n_state = hed_pkg::ST_UTF;
                    end else if (n_q != '0) begin
                        n_state = hed_pkg::ST_FEED;
                    end else if (r_last && n_cnt != '0) begin
                        n_state = hed_pkg::ST_FLUSH;
                    end else begin
                        n_state = hed_pkg::ST_IDLE;
                    end
                end
            end
            hed_pkg::ST_UTF: begin
                if (slot_free && utf_done) begin
                    n_state = (r_q != '0) ? hed_pkg::ST_FEED : hed_pkg::ST_IDLE;
                end
            end
            hed_pkg::ST_FLUSH: begin
                if (slot_free && r_cnt == CW'(1)) begin
                    n_state = hed_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = hed_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_buf[rd_addr] <= i_s_tdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= hed_pkg::ST_IDLE;
            r_head      <= '0;
            r_cnt       <= '0;
            r_q         <= '0;
            r_last      <= 1'b0;
            r_len       <= 3'd1;
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_head      <= n_head;
            r_cnt       <= n_cnt;
            r_q         <= n_q;
            r_last      <= n_last;
            r_len       <= n_len;
            r_idx       <= n_idx;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_byte <= n_out_byte;
        r_out_last <= n_out_last;
    end

endmodule

@@ sv/hed_checker.sv @@
module hed_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_s_tvalid,
    input logic       o_s_tready,
    input logic       o_m_tvalid,
    input logic       i_m_tready,
    input logic [7:0] o_m_tdata,
    input logic       o_m_tlast
);

    // a stalled output word stays
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid)
        else $error("output word dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> $stable(o_m_tdata) && $stable(o_m_tlast))
        else $error("output word changed while stalled");

    // every accepted byte needs at least one feed step before the next
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_tvalid && o_s_tready |=> !o_s_tready)
        else $error("input taken on consecutive cycles");

    a_reset_state: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid && o_s_tready)
        else $error("block not idle after reset");

endmodule

bind html_entity_decoder hed_checker u_hed_checker (.*);
